// ===== hdl/imu_dr_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the dead-reckoning integrator files.
// No dependencies.
package imu_dr_pkg;

  localparam int unsigned DVD_W = 66;
  localparam int unsigned DVS_W = 37;
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned Q_W = 48;

  localparam logic [24:0] FULL_TURN = 25'd23592960;
  localparam logic [DVD_W-1:0] INTEG_HALF = 66'd65536000000;
  localparam logic [DVD_W-1:0] POS_HALF = 66'd1000000;
  localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 32'd1000000;
  // floor(2^48 / 10^6) and floor(2^32 / one turn)
  localparam logic [MUL_B_W-1:0] USEC_RECIP = 32'd281474976;
  localparam logic [MUL_B_W-1:0] TURN_RECIP = 32'd182;

  localparam logic [7:0] CFG_GYRO_OFFSET = 8'd0;
  localparam logic [7:0] CFG_ACCEL_SCALE = 8'd1;
  localparam logic [7:0] CFG_GYRO_SCALE = 8'd2;
  localparam logic [7:0] CFG_DEADBAND = 8'd3;

  localparam logic [31:0] ACCEL_SCALE_RST = 32'd2569011;
  localparam logic [31:0] GYRO_SCALE_RST = 32'd65536000;
  localparam logic [15:0] DEADBAND_RST = 16'd655;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        period_us;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic [24:0]        load_heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [24:0]        heading;
    logic signed [31:0] turn_rate;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] data;
  } cfg_beat_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hdl/imu_dr_in_if.sv =====
`timescale 1ns / 1ps
// Sample/load request channel.
// Depends on imu_dr_pkg.
interface imu_dr_in_if;
  logic                valid;
  logic                ready;
  imu_dr_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/imu_dr_out_if.sv =====
`timescale 1ns / 1ps
// Result channel.
// Depends on imu_dr_pkg.
interface imu_dr_out_if;
  logic                 valid;
  logic                 ready;
  imu_dr_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/imu_dr_cfg_if.sv =====
`timescale 1ns / 1ps
// Register write channel.
// Depends on imu_dr_pkg.
interface imu_dr_cfg_if;
  logic                 valid;
  logic                 ready;
  imu_dr_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/imu_dr_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on imu_dr_pkg.
module imu_dr_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imu_dr_pkg::div_req_t req,
  output imu_dr_pkg::div_rsp_t rsp
);
  localparam int unsigned DVD_W = imu_dr_pkg::DVD_W;
  localparam int unsigned DVS_W = imu_dr_pkg::DVS_W;

  logic             busy_r, busy_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quot_r, quot_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W+1:0] trial;

  always_comb begin
    trial = {1'b0, rem_r, quot_r[DVD_W-1]} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    quot_nxt = quot_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      quot_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (busy_r) begin
      if (trial[DVS_W+1]) begin
        rem_nxt = {rem_r[DVS_W-2:0], quot_r[DVD_W-1]};
        quot_nxt = {quot_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quot_nxt = {quot_r[DVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.quot = quot_r;
  assign rsp.rem = rem_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < 7'(DVD_W)) else $error("divider step count out of range");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && dvs_r != '0 |-> rem_r < dvs_r) else $error("partial remainder not reduced");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == 7'(DVD_W - 1) && !req.start |=> !busy_r)
    else $error("divider did not finish");
endmodule

// ===== hdl/imu_dead_reckoning_integrator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the IMU dead-reckoning integrator: sequencer, shared multiplier, divider.
// Depends on imu_dr_pkg, the channel interfaces and imu_dr_div.
//
//  channel   dir  payload                                      handshake
//  in_chan   in   req_type, accel_x/y, gyro_z, period_us, load  valid/ready
//  out_chan  out  pos_x/y, vel_x/y, heading, turn_rate          valid/ready
//  cfg_chan  in   index, data                                   valid/ready (always ready)
//
// A load request goes from idle straight to the output state. A sample runs seven
// jobs through one 34x32 multiplier: six end in a reciprocal multiply, a back
// multiply and at most three correction subtracts, the turn rate in a 66-bit
// divider that yields one quotient bit per cycle. The output state then loads
// the result into the output register.
// Synchronous active-low reset sets control, config and navigation state to reset values.
// in_chan is ready only while idle; a stalled result holds in the output register.
module imu_dead_reckoning_integrator_unit (
  input logic       clk,
  input logic       rst_n,
  imu_dr_in_if.sink    in_chan,
  imu_dr_out_if.source out_chan,
  imu_dr_cfg_if.sink   cfg_chan
);
  localparam int unsigned DVD_W = imu_dr_pkg::DVD_W;
  localparam int unsigned MA_W = imu_dr_pkg::MUL_A_W;
  localparam int unsigned MB_W = imu_dr_pkg::MUL_B_W;
  localparam int unsigned Q_W = imu_dr_pkg::Q_W;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_MULA = 10'b0000000010,
    ST_MULB = 10'b0000000100,
    ST_RCPA = 10'b0000001000,
    ST_RCPB = 10'b0000010000,
    ST_FIX  = 10'b0000100000,
    ST_DIVS = 10'b0001000000,
    ST_DIVW = 10'b0010000000,
    ST_POST = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    J_VX   = 3'd0,
    J_VY   = 3'd1,
    J_PX   = 3'd2,
    J_PY   = 3'd3,
    J_DH   = 3'd4,
    J_HMOD = 3'd5,
    J_TURN = 3'd6
  } job_t;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;

  logic signed [15:0] gz_off_r;
  logic [31:0]        accel_scale_r, gyro_scale_r;
  logic [15:0]        deadband_r;

  logic signed [31:0] vel_x_r, vel_y_r, pos_x_r, pos_y_r;
  logic signed [31:0] vx_new_r, vy_new_r;
  logic signed [15:0] last_ax_r, last_ay_r, last_g_r;
  logic [24:0]        heading_r, last_head_r;

  logic signed [15:0] ax_r, ay_r, g_r;
  logic [15:0]        p_r;
  logic               neg_r;
  logic [DVD_W-1:0]   prod_r;
  logic signed [36:0] hsum_r;
  logic signed [31:0] turn_r;
  logic [Q_W-1:0]     qt_r;
  logic [31:0]        rm_r;

  logic                  out_valid_r;
  imu_dr_pkg::out_beat_t out_data_r;

  logic signed [36:0] op_sum;
  logic [36:0]        op_mag;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [DVD_W-1:0]   mul_p;
  logic [DVD_W-1:0]   y_sum;
  logic [Q_W-1:0]     y_val;
  logic [31:0]        d_val;
  logic signed [16:0] g_diff;
  logic signed [15:0] g_sat;
  logic [Q_W-1:0]     q;
  logic signed [Q_W:0] sq;
  logic signed [Q_W:0] dh;
  logic [24:0]        rem25;
  logic [24:0]        load_h;
  logic               in_acc;

  imu_dr_pkg::div_req_t div_req;
  imu_dr_pkg::div_rsp_t div_rsp;

  imu_dr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data = out_data_r;

  // rounded dividend and constant divisor of the reciprocal jobs
  always_comb begin
    case (job_r)
      J_VX, J_VY, J_DH: begin
        y_sum = prod_r + imu_dr_pkg::INTEG_HALF;
        y_val = y_sum[64:17];
      end
      J_PX, J_PY: begin
        y_sum = prod_r + imu_dr_pkg::POS_HALF;
        y_val = y_sum[48:1];
      end
      default: begin
        y_sum = prod_r;
        y_val = y_sum[Q_W-1:0];
      end
    endcase
    d_val = (job_r == J_HMOD) ? 32'(imu_dr_pkg::FULL_TURN) : imu_dr_pkg::USEC_PER_SEC;
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (job_r)
      J_VX:    op_sum = 37'(ax_r) + 37'(last_ax_r);
      J_VY:    op_sum = 37'(ay_r) + 37'(last_ay_r);
      J_PX:    op_sum = 37'(vx_new_r) + 37'(vel_x_r);
      J_PY:    op_sum = 37'(vy_new_r) + 37'(vel_y_r);
      J_DH:    op_sum = 37'(g_r) + 37'(last_g_r);
      J_HMOD:  op_sum = hsum_r;
      J_TURN:  op_sum = 37'($signed({1'b0, heading_r})) - 37'($signed({1'b0, last_head_r}));
      default: op_sum = '0;
    endcase
    op_mag = op_sum[36] ? 37'(-op_sum) : 37'(op_sum);
    case (state_r)
      ST_MULB: begin
        mul_a = prod_r[MA_W-1:0];
        mul_b = (job_r == J_DH) ? gyro_scale_r : accel_scale_r;
      end
      ST_RCPA: begin
        if (job_r == J_HMOD) begin
          mul_a = y_val[MA_W-1:0];
          mul_b = imu_dr_pkg::TURN_RECIP;
        end else begin
          mul_a = MA_W'(y_val[47:16]);
          mul_b = imu_dr_pkg::USEC_RECIP;
        end
      end
      ST_RCPB: begin
        mul_a = qt_r[MA_W-1:0];
        mul_b = d_val;
      end
      default: begin
        mul_a = op_mag[MA_W-1:0];
        case (job_r)
          J_TURN:  mul_b = imu_dr_pkg::USEC_PER_SEC;
          J_HMOD:  mul_b = 32'd1;
          default: mul_b = {16'd0, p_r};
        endcase
      end
    endcase
    mul_p = DVD_W'(mul_a) * DVD_W'(mul_b);
  end

  // divider request, turn rate only
  always_comb begin
    div_req.start = (state_r == ST_DIVS);
    div_req.dividend = prod_r + DVD_W'(p_r >> 1);
    div_req.divisor = 37'(p_r);
  end

  always_comb begin
    q = (job_r == J_TURN) ? div_rsp.quot[Q_W-1:0] : qt_r;
    sq = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    dh = (q < Q_W'(deadband_r)) ? '0 : sq;
    rem25 = rm_r[24:0];
    g_diff = 17'(in_chan.data.gyro_z) - 17'(gz_off_r);
    if (g_diff > 17'sd32767) begin
      g_sat = 16'sh7fff;
    end else if (g_diff < -17'sd32768) begin
      g_sat = 16'sh8000;
    end else begin
      g_sat = g_diff[15:0];
    end
    load_h = (in_chan.data.load_heading >= imu_dr_pkg::FULL_TURN) ?
             in_chan.data.load_heading - imu_dr_pkg::FULL_TURN : in_chan.data.load_heading;
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_chan.data.req_type ? ST_OUT : ST_MULA;
          job_nxt = J_VX;
        end
      end
      ST_MULA: begin
        if (job_r == J_VX || job_r == J_VY || job_r == J_DH) begin
          state_nxt = ST_MULB;
        end else if (job_r == J_TURN) begin
          state_nxt = ST_DIVS;
        end else begin
          state_nxt = ST_RCPA;
        end
      end
      ST_MULB: state_nxt = ST_RCPA;
      ST_RCPA: state_nxt = ST_RCPB;
      ST_RCPB: state_nxt = ST_FIX;
      ST_FIX: if (rm_r < d_val) state_nxt = ST_POST;
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: if (!div_rsp.busy) state_nxt = ST_POST;
      ST_POST: begin
        if (job_r == J_TURN) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MULA;
          job_nxt = job_t'(job_r + 3'd1);
        end
      end
      ST_OUT: if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r <= J_VX;
      out_valid_r <= 1'b0;
      gz_off_r <= '0;
      accel_scale_r <= imu_dr_pkg::ACCEL_SCALE_RST;
      gyro_scale_r <= imu_dr_pkg::GYRO_SCALE_RST;
      deadband_r <= imu_dr_pkg::DEADBAND_RST;
      vel_x_r <= '0;
      vel_y_r <= '0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      last_ax_r <= '0;
      last_ay_r <= '0;
      last_g_r <= '0;
      heading_r <= '0;
      last_head_r <= '0;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.data.index)
          imu_dr_pkg::CFG_GYRO_OFFSET: gz_off_r <= cfg_chan.data.data[15:0];
          imu_dr_pkg::CFG_ACCEL_SCALE: accel_scale_r <= cfg_chan.data.data;
          imu_dr_pkg::CFG_GYRO_SCALE:  gyro_scale_r <= cfg_chan.data.data;
          imu_dr_pkg::CFG_DEADBAND:    deadband_r <= cfg_chan.data.data[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_chan.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_chan.data.req_type) begin
            pos_x_r <= in_chan.data.load_x;
            pos_y_r <= in_chan.data.load_y;
            heading_r <= load_h;
          end
        end
        ST_POST: begin
          case (job_r)
            J_PX: pos_x_r <= imu_dr_pkg::sat32(50'(pos_x_r) + 50'(sq));
            J_PY: begin
              pos_y_r <= imu_dr_pkg::sat32(50'(pos_y_r) + 50'(sq));
              vel_x_r <= vx_new_r;
              vel_y_r <= vy_new_r;
            end
            J_HMOD: begin
              if (neg_r) begin
                heading_r <= (rem25 == '0) ? '0 : imu_dr_pkg::FULL_TURN - rem25;
              end else begin
                heading_r <= rem25;
              end
            end
            J_TURN: begin
              last_head_r <= heading_r;
              last_ax_r <= ax_r;
              last_ay_r <= ay_r;
              last_g_r <= g_r;
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= in_chan.data.accel_x;
      ay_r <= in_chan.data.accel_y;
      g_r <= g_sat;
      p_r <= (in_chan.data.period_us == '0) ? 16'd1 : in_chan.data.period_us;
      turn_r <= '0;
    end
    if (state_r == ST_MULA || state_r == ST_MULB) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_MULA) begin
      neg_r <= op_sum[36];
    end
    if (state_r == ST_RCPA) begin
      qt_r <= Q_W'(mul_p[DVD_W-1:32]);
    end
    if (state_r == ST_RCPB) begin
      rm_r <= 32'(y_val - mul_p[Q_W-1:0]);
    end
    if (state_r == ST_FIX && rm_r >= d_val) begin
      rm_r <= rm_r - d_val;
      qt_r <= qt_r + Q_W'(1);
    end
    if (state_r == ST_POST) begin
      case (job_r)
        J_VX:   vx_new_r <= imu_dr_pkg::sat32(50'(vel_x_r) + 50'(sq));
        J_VY:   vy_new_r <= imu_dr_pkg::sat32(50'(vel_y_r) + 50'(sq));
        J_DH:   hsum_r <= 37'($signed({1'b0, heading_r})) + 37'(dh);
        J_TURN: turn_r <= imu_dr_pkg::sat32(50'(sq));
        default: ;
      endcase
    end
    if (state_r == ST_OUT && (!out_valid_r || out_chan.ready)) begin
      out_data_r.pos_x <= pos_x_r;
      out_data_r.pos_y <= pos_y_r;
      out_data_r.vel_x <= vel_x_r;
      out_data_r.vel_y <= vel_y_r;
      out_data_r.heading <= heading_r;
      out_data_r.turn_rate <= turn_r;
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready) else $error("input taken while a beat is in work");
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    heading_r < imu_dr_pkg::FULL_TURN && last_head_r < imu_dr_pkg::FULL_TURN)
    else $error("heading outside one turn");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVS |-> !div_rsp.busy) else $error("divider started while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && !out_chan.ready |=> state_r == ST_OUT)
    else $error("result overwritten while stalled");
endmodule

// ===== tb/imu_dr_tb_if_note.sv =====
`timescale 1ns / 1ps
// Shared testbench types for the dead-reckoning integrator bench.
// Depends on imu_dr_pkg.
package imu_dr_tb_pkg;
  import imu_dr_pkg::*;

  typedef struct {
    bit        is_cfg;
    bit [7:0]  index;
    bit [31:0] data;
    in_beat_t  beat;
    bit        has_exp;
    out_beat_t exp;
  } stim_row_t;
endpackage

// ===== tb/imu_dead_reckoning_integrator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for imu_dead_reckoning_integrator_unit: directed table then
// random samples and loads, checked against an in-bench fixed-point predictor.
// Depends on imu_dr_pkg, imu_dr_tb_pkg, the channel interfaces and the unit.
module imu_dead_reckoning_integrator_unit_tb;
  import imu_dr_pkg::*;
  import imu_dr_tb_pkg::*;

  localparam longint TURN = 23592960;
  localparam int LIMIT = 3000000;
  localparam logic [7:0] CFG_NONE = 8'd9;

  logic clk;
  logic rst_n;
  imu_dr_in_if in_chan ();
  imu_dr_out_if out_chan ();
  imu_dr_cfg_if cfg_chan ();

  imu_dead_reckoning_integrator_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  // predictor state
  longint gz_off, a_scale, g_scale, dband;
  longint vx_s, vy_s, px_s, py_s, lax, lay, lgz, hacc, lhead;
  out_beat_t nav_q[$];
  int errors, n_out, n_in, n_load, cycles;
  bit hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("imu_dead_reckoning_integrator_unit verification failed");
      $finish;
    end
  end

  function automatic longint sat32l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint unsigned div);
    longint unsigned m;
    longint unsigned q;
    m = (num < 0) ? longint'(-num) : longint'(num);
    q = (m + div / 2) / div;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // sum * scale * p can reach ~2^17*2^32*2^16: use 128-bit intermediate
  function automatic longint trap_inc(longint sum, longint scale, longint p);
    bit [127:0] m;
    bit [127:0] q;
    m = (sum < 0) ? 128'(-sum) : 128'(sum);
    m = m * 128'(scale) * 128'(p);
    q = (m + 128'd65536000000) / 128'd131072000000;
    return (sum < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic reset_model();
    gz_off = 0; a_scale = 2569011; g_scale = 65536000; dband = 655;
    vx_s = 0; vy_s = 0; px_s = 0; py_s = 0; lax = 0; lay = 0; lgz = 0; hacc = 0; lhead = 0;
  endtask

  task automatic model_cfg(bit [7:0] idx, bit [31:0] d);
    case (idx)
      CFG_GYRO_OFFSET: gz_off = longint'($signed(d[15:0]));
      CFG_ACCEL_SCALE: a_scale = longint'(d);
      CFG_GYRO_SCALE: g_scale = longint'(d);
      CFG_DEADBAND: dband = longint'(d[15:0]);
      default: ;
    endcase
  endtask

  function automatic out_beat_t predict_nav(in_beat_t b);
    out_beat_t r;
    longint ax, ay, g, p, nvx, nvy, dh, h, turn;
    turn = 0;
    if (b.req_type) begin
      h = longint'(b.load_heading);
      if (h >= TURN) h -= TURN;
      px_s = longint'(b.load_x); py_s = longint'(b.load_y); hacc = h;
    end else begin
      ax = longint'(b.accel_x); ay = longint'(b.accel_y);
      g = longint'(b.gyro_z) - gz_off;
      p = longint'(b.period_us);
      if (p == 0) p = 1;
      if (g > 32767) g = 32767;
      if (g < -32768) g = -32768;
      nvx = sat32l(vx_s + trap_inc(ax + lax, a_scale, p));
      nvy = sat32l(vy_s + trap_inc(ay + lay, a_scale, p));
      px_s = sat32l(px_s + round_div((nvx + vx_s) * p, 2000000));
      py_s = sat32l(py_s + round_div((nvy + vy_s) * p, 2000000));
      vx_s = nvx; vy_s = nvy;
      dh = trap_inc(g + lgz, g_scale, p);
      if (((dh < 0) ? -dh : dh) < dband) dh = 0;
      h = (hacc + dh) % TURN;
      if (h < 0) h += TURN;
      hacc = h;
      turn = sat32l(round_div((hacc - lhead) * 1000000, p));
      lhead = hacc; lax = ax; lay = ay; lgz = g;
    end
    r.pos_x = px_s[31:0]; r.pos_y = py_s[31:0];
    r.vel_x = vx_s[31:0]; r.vel_y = vy_s[31:0];
    r.heading = hacc[24:0]; r.turn_rate = turn[31:0];
    return r;
  endfunction

  function automatic in_beat_t sample(int ax, int ay, int gz, int p);
    in_beat_t b;
    b = '0;
    b.accel_x = ax[15:0]; b.accel_y = ay[15:0]; b.gyro_z = gz[15:0]; b.period_us = p[15:0];
    b.load_x = $urandom; b.load_y = $urandom; b.load_heading = 25'($urandom);
    return b;
  endfunction

  function automatic in_beat_t load_req(int x, int y, int h);
    in_beat_t b;
    b = '0;
    b.req_type = 1'b1;
    b.accel_x = 16'($urandom); b.accel_y = 16'($urandom); b.gyro_z = 16'($urandom);
    b.period_us = 16'($urandom);
    b.load_x = x; b.load_y = y; b.load_heading = h[24:0];
    return b;
  endfunction

  function automatic in_beat_t rand_beat();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return load_req($urandom, $urandom, $urandom_range(0, 33554431));
    if (sel < 3) return sample($urandom, $urandom, $urandom, $urandom);
    return sample($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                  $urandom_range(0, 4000) - 2000, $urandom_range(1, 20000));
  endfunction

  task automatic send_beat(in_beat_t b);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    nav_q.push_back(predict_nav(b));
    n_in++;
    if (b.req_type) n_load++;
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(bit [7:0] idx, bit [31:0] d);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= '{index: idx, data: d};
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    model_cfg(idx, d);
    @(posedge clk);
  endtask

  task automatic drain();
    while (nav_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= !hold_off && (cycles % 7 < 5 || $urandom_range(0, 1) == 1);
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_out++;
      if (nav_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat %h", $time, out_chan.data);
      end else begin
        e = nav_q.pop_front();
        if (out_chan.data.pos_x !== e.pos_x || out_chan.data.pos_y !== e.pos_y ||
            out_chan.data.vel_x !== e.vel_x || out_chan.data.vel_y !== e.vel_y ||
            out_chan.data.heading !== e.heading || out_chan.data.turn_rate !== e.turn_rate) begin
          errors++;
          $display("%0t mismatch exp %h act %h", $time, e, out_chan.data);
        end
      end
    end
  end

  initial begin
    stim_row_t tbl[$];
    stim_row_t row;
    out_beat_t pr;
    int k;
    errors = 0; n_out = 0; n_in = 0; n_load = 0; cycles = 0; hold_off = 0;
    rst_n = 0;
    in_chan.valid = 0; in_chan.data = '0;
    cfg_chan.valid = 0; cfg_chan.data = '0;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row = '{default: '0};
    row.beat = sample(0, 0, 0, 1000); row.has_exp = 1; row.exp = '0; tbl.push_back(row);
    row = '{default: '0};
    row.beat = load_req(0, 0, 23592960); row.has_exp = 1; row.exp = '0; tbl.push_back(row);
    row = '{default: '0};
    row.beat = load_req(32'h7fffffff, 32'h80000000, 23592959); row.has_exp = 1;
    row.exp = '{pos_x: 32'h7fffffff, pos_y: 32'h80000000, vel_x: 0, vel_y: 0,
                heading: 25'd23592959, turn_rate: 0};
    tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(32767, -32768, 32767, 0); tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(32767, -32768, -32768, 65535); tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(-32768, 32767, 3, 100); tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_GYRO_OFFSET; row.data = 32'h8000;
    tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(100, 100, 32767, 1000); tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_GYRO_OFFSET; row.data = 32'h7fff;
    tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(0, 0, -32768, 1000); tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_ACCEL_SCALE; row.data = '1;
    tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_GYRO_SCALE; row.data = '1;
    tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_DEADBAND; row.data = 32'hffff;
    tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(32767, 32767, 32767, 65535); tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(1, -1, 1, 1); tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_NONE; row.data = '1;
    tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_DEADBAND; row.data = 0;
    tbl.push_back(row);
    row = '{default: '0}; row.is_cfg = 1; row.index = CFG_ACCEL_SCALE; row.data = 0;
    tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(-5, 5, -32768, 65535); tbl.push_back(row);
    row = '{default: '0}; row.beat = load_req(-1, 1, 33554431); tbl.push_back(row);
    row = '{default: '0}; row.beat = sample(0, 0, 0, 2); tbl.push_back(row);

    foreach (tbl[i]) begin
      if (tbl[i].is_cfg) begin
        drain();
        write_reg(tbl[i].index, tbl[i].data);
      end else begin
        send_beat(tbl[i].beat);
        if (tbl[i].has_exp) begin
          pr = nav_q[$];
          if (pr !== tbl[i].exp) begin
            errors++;
            $display("%0t table row %0d exp %h act %h", $time, i, tbl[i].exp, pr);
          end
        end
      end
    end

    // long receiver hold-off while samples keep coming
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      for (k = 0; k < 6; k++) send_beat(rand_beat());
    join

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_ACCEL_SCALE, 32'd2569011); write_reg(CFG_GYRO_SCALE, 32'd65536000);
          write_reg(CFG_DEADBAND, 32'd655); write_reg(CFG_GYRO_OFFSET, 0);
        end
        1: begin
          write_reg(CFG_ACCEL_SCALE, $urandom); write_reg(CFG_GYRO_SCALE, $urandom);
          write_reg(CFG_DEADBAND, $urandom); write_reg(CFG_GYRO_OFFSET, $urandom);
        end
        2: begin
          write_reg(CFG_ACCEL_SCALE, 0); write_reg(CFG_GYRO_SCALE, 0);
          write_reg(CFG_DEADBAND, 0); write_reg(CFG_GYRO_OFFSET, 32'h8000);
        end
        default: begin
          write_reg(CFG_ACCEL_SCALE, 32'd40000000); write_reg(CFG_GYRO_SCALE, 32'd900000000);
          write_reg(CFG_DEADBAND, 32'd10); write_reg(CFG_GYRO_OFFSET, 32'd12);
        end
      endcase
      for (k = 0; k < 130; k++) send_beat(rand_beat());
    end

    drain();
    repeat (600) @(posedge clk);
    $display("Run covered %0d requests (%0d loads), %0d results, four register settings.",
             n_in, n_load, n_out);
    if (errors == 0 && nav_q.size() == 0) begin
      $display("imu_dead_reckoning_integrator_unit verification clean");
    end else begin
      $display("imu_dead_reckoning_integrator_unit verification failed");
    end
    $finish;
  end
endmodule
